@@ design/bmie_pkg.sv @@
// Package for the byte machine instruction executor.
// Operation codes, status codes, sizes and the sequencer state type. No dependencies.
package bmie_pkg;

    localparam int RegCount   = 8;
    localparam int LabelCount = 16;
    localparam int MemDepth   = 256;
    localparam int RegIdxW    = (RegCount > 1) ? $clog2(RegCount) : 1;
    localparam int LabIdxW    = (LabelCount > 1) ? $clog2(LabelCount) : 1;
    localparam int MemAddrW   = $clog2(MemDepth);

    localparam logic [4:0] OP_NOP = 5'd0;
    localparam logic [4:0] OP_MOV = 5'd1;
    localparam logic [4:0] OP_ADD = 5'd2;
    localparam logic [4:0] OP_ADC = 5'd3;
    localparam logic [4:0] OP_SUB = 5'd4;
    localparam logic [4:0] OP_SBC = 5'd5;
    localparam logic [4:0] OP_MUL = 5'd6;
    localparam logic [4:0] OP_DIV = 5'd7;
    localparam logic [4:0] OP_SHL = 5'd8;
    localparam logic [4:0] OP_SHR = 5'd9;
    localparam logic [4:0] OP_CLC = 5'd10;
    localparam logic [4:0] OP_CLV = 5'd11;
    localparam logic [4:0] OP_NEG = 5'd12;
    localparam logic [4:0] OP_STR = 5'd13;
    localparam logic [4:0] OP_LD  = 5'd14;
    localparam logic [4:0] OP_CMP = 5'd15;
    localparam logic [4:0] OP_JMP = 5'd16;
    localparam logic [4:0] OP_JNE = 5'd17;
    localparam logic [4:0] OP_JE  = 5'd18;
    localparam logic [4:0] OP_JGT = 5'd19;
    localparam logic [4:0] OP_JLT = 5'd20;
    localparam logic [4:0] OP_JNZ = 5'd21;
    localparam logic [4:0] OP_JZ  = 5'd22;
    localparam logic [4:0] OP_PRC = 5'd23;
    localparam logic [4:0] OP_PRS = 5'd24;
    localparam logic [4:0] OP_PRU = 5'd25;
    localparam logic [4:0] OP_HLT = 5'd26;
    localparam logic [4:0] OP_LBL = 5'd27;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_BAD_OPD = 2'd2;
    localparam logic [1:0] ST_BAD_INS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SERIAL,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

@@ design/byte_machine_instruction_executor.sv @@
// Top level of the byte machine instruction executor.
// Depends on bmie_pkg; holds register file, data memory, labels and bit-serial ALU.
//
// Channel  Dir  tdata (low bit first)                                  tuser
// s_axis   in   operation[4:0], first_value[12:5], first_is_register[13],
//               first_is_label[14], second_value[22:15],
//               second_is_register[23], second_is_label[24]            -
// m_axis   out  status[1:0], next_pointer[9:2], print_valid[10],
//               print_kind[12:11], print_value[20:13]                  -
//
// One item at a time: accept, operand/memory read (S_READ), the shared
// bit-serial unit (S_SERIAL; add/sub/mul/div/shift one bit per cycle),
// write-back (S_WRITE), then the result is held in S_OUT until taken; the
// next item is taken only after that. The data memory is cleared by a pass
// over every address after reset, during which no item is accepted. A stalled
// output holds the block.
module byte_machine_instruction_executor
    import bmie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op, v1, r1, l1, v2, r2, l2
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, next, pv, pk, pval
);

    t_state r_state, n_state;

    logic [7:0] r_regs [RegCount];
    logic [7:0] r_labels [LabelCount];
    logic [7:0] r_mem [MemDepth];
    logic       r_carry, r_ovf, r_nz;
    logic [3:0] r_cmp;
    logic [7:0] r_ip;

    logic                r_clr_busy;
    logic [MemAddrW-1:0] r_clr_addr;

    // latched instruction
    logic [4:0] r_op;
    logic [7:0] r_v1, r_v2;
    logic       r_r1, r_l1, r_r2, r_l2;

    // operands and serial datapath
    logic [7:0] r_d, r_b, r_mrd;
    logic [7:0] r_acc;      // result shift register / product / remainder
    logic [7:0] r_sh;       // shifting operand
    logic [7:0] r_q;        // quotient
    logic       r_cy;       // serial carry/borrow
    logic       r_sgn;      // final signed overflow
    logic [2:0] r_cnt;

    logic [23:0] r_out;

    // operand validity
    logic       v1_reg_ok, v2_reg_ok, dst_ok, a_ok, b_ok, lab_ok;
    logic [7:0] a_val, b_val;

    always_comb begin
        v1_reg_ok = ({24'd0, r_v1} < RegCount);
        v2_reg_ok = ({24'd0, r_v2} < RegCount);
        dst_ok    = r_r1 && !r_l1 && v1_reg_ok;
        a_ok      = r_r1 ? v1_reg_ok : !r_l1;
        b_ok      = r_r2 ? v2_reg_ok : !r_l2;
        lab_ok    = r_l1 && ({24'd0, r_v1} < LabelCount);
        a_val     = r_r1 ? r_regs[r_v1[RegIdxW-1:0]] : r_v1;
        b_val     = r_r2 ? r_regs[r_v2[RegIdxW-1:0]] : r_v2;
    end

    // serial step signals
    logic       sub_op, adc_op, sbc_op;
    logic       sum_bit, sum_cy;
    logic [8:0] trial;

    always_comb begin
        sub_op  = (r_op == OP_SUB) || (r_op == OP_SBC);
        adc_op  = (r_op == OP_ADC);
        sbc_op  = (r_op == OP_SBC);
        // one bit of add or subtract (subtract as d + ~b + 1 - c)
        sum_bit = r_d[r_cnt] ^ (r_b[r_cnt] ^ sub_op) ^ r_cy;
        sum_cy  = (r_d[r_cnt] & (r_b[r_cnt] ^ sub_op)) |
                  (r_cy & (r_d[r_cnt] ^ r_b[r_cnt] ^ sub_op));
        // restoring divide step on remainder r_acc
        trial   = {r_acc, r_sh[7]} - {1'b0, r_b};
    end

    logic [7:0] result;
    logic       res_carry, res_ovf;

    always_comb begin
        result    = r_acc;
        res_carry = 1'b0;
        res_ovf   = r_sgn;
        unique case (r_op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC: result = r_acc;
            OP_MUL:                         result = r_acc;
            OP_DIV:                         result = (r_b == 8'd0) ? 8'hFF : r_q;
            OP_SHL, OP_SHR:                 result = (r_b >= 8'd8) ? 8'd0 : r_sh;
            default:                        result = r_b;
        endcase
        // final carry: add carry-out set, sub carry-out clear means borrow
        res_carry = sub_op ? !r_cy : r_cy;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) n_state = S_READ;
            S_READ:   n_state = S_SERIAL;
            S_SERIAL: if (r_cnt == 3'd7) n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory clear pass and memory access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MemAddrW'(MemDepth - 1)) r_clr_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (r_state == S_WRITE && r_op == OP_STR && a_ok && b_ok) begin
            r_mem[a_val[MemAddrW-1:0]] <= b_val;
        end
        r_mrd <= r_mem[b_val[MemAddrW-1:0]];
    end

    // datapath
    logic [1:0] st;
    logic [7:0] nxt;
    logic       take;

    always_comb begin
        st   = ST_OK;
        take = 1'b0;
        unique case (r_op)
            OP_JMP: take = 1'b1;
            OP_JNE: take = r_cmp[0];
            OP_JE:  take = r_cmp[1];
            OP_JGT: take = r_cmp[2];
            OP_JLT: take = r_cmp[3];
            OP_JNZ: take = r_nz;
            OP_JZ:  take = !r_nz;
            default: take = 1'b0;
        endcase
        priority if (r_op >= OP_MOV && r_op <= OP_SHR) begin
            if (!dst_ok || !b_ok) st = ST_BAD_OPD;
        end else if (r_op == OP_NEG) begin
            if (!r_r2 || !v2_reg_ok) st = ST_BAD_OPD;
        end else if (r_op == OP_STR || r_op == OP_CMP) begin
            if (!a_ok || !b_ok) st = ST_BAD_OPD;
        end else if (r_op == OP_LD) begin
            if (!dst_ok || !b_ok) st = ST_BAD_OPD;
        end else if ((r_op >= OP_JMP && r_op <= OP_JZ) || r_op == OP_LBL) begin
            if (!lab_ok) st = ST_BAD_OPD;
        end else if (r_op >= OP_PRC && r_op <= OP_PRU) begin
            if (!a_ok) st = ST_BAD_OPD;
        end else if (r_op == OP_HLT) begin
            st = ST_HALTED;
        end else if (r_op == OP_NOP || r_op == OP_CLC || r_op == OP_CLV) begin
            st = ST_OK;
        end else begin
            st = ST_BAD_INS;
        end
        if (st != ST_OK) begin
            nxt = r_ip;
        end else if (r_op >= OP_JMP && r_op <= OP_JZ && take) begin
            nxt = r_labels[r_v1[LabIdxW-1:0]];
        end else begin
            nxt = r_ip + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RegCount; i++) r_regs[i] <= 8'd0;
            for (int i = 0; i < LabelCount; i++) r_labels[i] <= 8'd0;
            r_carry <= 1'b0;
            r_ovf   <= 1'b0;
            r_nz    <= 1'b0;
            r_cmp   <= 4'd0;
            r_ip    <= 8'd0;
            r_cnt   <= 3'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op <= s_axis_tdata[4:0];
                        r_v1 <= s_axis_tdata[12:5];
                        r_r1 <= s_axis_tdata[13];
                        r_l1 <= s_axis_tdata[14];
                        r_v2 <= s_axis_tdata[22:15];
                        r_r2 <= s_axis_tdata[23];
                        r_l2 <= s_axis_tdata[24];
                    end
                end
                S_READ: begin
                    r_d   <= r_regs[r_v1[RegIdxW-1:0]];
                    r_b   <= b_val;
                    r_cnt <= 3'd0;
                    r_acc <= 8'd0;
                    r_q   <= 8'd0;
                    r_sgn <= 1'b0;
                    unique case (r_op)
                        OP_ADD:  r_cy <= 1'b0;
                        OP_SUB:  r_cy <= 1'b1;
                        OP_ADC:  r_cy <= r_carry;
                        OP_SBC:  r_cy <= !r_carry;
                        default: r_cy <= 1'b0;
                    endcase
                    r_sh <= r_regs[r_v1[RegIdxW-1:0]];
                end
                S_SERIAL: begin
                    r_cnt <= r_cnt + 3'd1;
                    unique case (r_op)
                        OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
                            r_acc <= {sum_bit, r_acc[7:1]};
                            r_cy  <= sum_cy;
                            if (r_cnt == 3'd7) r_sgn <= sum_cy ^ r_cy;
                        end
                        OP_MUL: begin
                            // shift-add, multiplier bits msb first
                            r_acc <= {r_acc[6:0], 1'b0} + (r_b[3'd7 - r_cnt] ? r_d : 8'd0);
                        end
                        OP_DIV: begin
                            r_sh <= {r_sh[6:0], 1'b0};
                            if (!trial[8]) begin
                                r_acc <= trial[7:0];
                                r_q   <= {r_q[6:0], 1'b1};
                            end else begin
                                r_acc <= {r_acc[6:0], r_sh[7]};
                                r_q   <= {r_q[6:0], 1'b0};
                            end
                        end
                        OP_SHL: if ({5'd0, r_cnt} < r_b) r_sh <= {r_sh[6:0], 1'b0};
                        OP_SHR: if ({5'd0, r_cnt} < r_b) r_sh <= {1'b0, r_sh[7:1]};
                        default: r_acc <= r_acc;
                    endcase
                end
                S_WRITE: begin
                    r_ip <= nxt;
                    if (st == ST_OK) begin
                        unique case (r_op)
                            OP_MOV: r_regs[r_v1[RegIdxW-1:0]] <= r_b;
                            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_MUL, OP_DIV,
                            OP_SHL, OP_SHR: begin
                                r_regs[r_v1[RegIdxW-1:0]] <= result;
                                r_nz <= (result != 8'd0);
                                if ((adc_op || sbc_op) && res_carry) r_carry <= 1'b1;
                                if ((adc_op || sbc_op) && res_ovf) r_ovf <= 1'b1;
                            end
                            OP_CLC: r_carry <= 1'b0;
                            OP_CLV: r_ovf <= 1'b0;
                            OP_NEG: r_regs[r_v2[RegIdxW-1:0]] <=
                                8'd0 - r_regs[r_v2[RegIdxW-1:0]];
                            OP_LD:  r_regs[r_v1[RegIdxW-1:0]] <= r_mrd;
                            OP_CMP: r_cmp <= {a_val < b_val, a_val > b_val,
                                              a_val == b_val, a_val != b_val};
                            OP_LBL: r_labels[r_v1[LabIdxW-1:0]] <= r_v2;
                            default: begin
                            end
                        endcase
                    end
                    r_out[1:0]  <= st;
                    r_out[9:2]  <= nxt;
                    if (st == ST_OK && r_op >= OP_PRC && r_op <= OP_PRU) begin
                        r_out[10]    <= 1'b1;
                        r_out[12:11] <= 2'(r_op - OP_PRC);
                        r_out[20:13] <= a_val;
                    end else begin
                        r_out[20:10] <= 11'd0;
                    end
                    r_out[23:21] <= 3'd0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready) else $error("item taken during memory clear");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_out))
        else $error("result changed under stall");
    a_serial_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_cnt == 3'd0)) else $error("serial count not reset");
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out[10]) |-> (r_out[1:0] == ST_OK))
        else $error("print with bad status");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the byte machine instruction executor.
// Depends on bmie_pkg and byte_machine_instruction_executor; predicts each result in-line.
`timescale 1ns / 1ps

module testbench;
    import bmie_pkg::*;

    typedef struct packed {
        logic       l2;
        logic       r2;
        logic [7:0] v2;
        logic       l1;
        logic       r1;
        logic [7:0] v1;
        logic [4:0] op;
    } t_instr;

    typedef struct packed {
        logic [7:0] pval;
        logic [1:0] pkind;
        logic       pvalid;
        logic [7:0] next;
        logic [1:0] status;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    byte_machine_instruction_executor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Machine state as the predictor sees it
    logic [7:0] gpr [RegCount];
    logic [7:0] dmem [MemDepth];
    logic [7:0] labels [LabelCount];
    logic       carry, ovf, nzero;
    logic [3:0] cmp_flags;
    logic [7:0] ip;

    t_instr   pending_instrs [$];
    t_outcome expected_outcomes [$];
    int       send_idle_pct, recv_stall_pct;
    int       mismatches, checked, prints_seen;
    longint   cycle_count;

    // Handshake seen at the last rising edge
    logic s_axis_tready_q;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Operand fetch; returns 0 when the operand gives no value
    function automatic bit fetch_operand(input logic [7:0] v, input logic r, input logic l,
                                         output logic [7:0] val);
        val = v;
        if (r) begin
            if (v >= RegCount) return 0;
            val = gpr[v[RegIdxW-1:0]];
            return 1;
        end
        return !l;
    endfunction

    function automatic bit dest_valid(input t_instr it);
        return it.r1 && !it.l1 && it.v1 < RegCount;
    endfunction

    function automatic t_outcome execute_instr(input t_instr it);
        t_outcome   o;
        logic [7:0] a, b, d, res;
        logic [8:0] wide;
        int         s;
        bit         take;
        o = '0;
        o.status = ST_OK;
        o.next = ip + 8'd1;
        if (it.op >= OP_MOV && it.op <= OP_SHR) begin
            if (!dest_valid(it) || !fetch_operand(it.v2, it.r2, it.l2, b)) begin
                o.status = ST_BAD_OPD;
            end else if (it.op == OP_MOV) begin
                gpr[it.v1[RegIdxW-1:0]] = b;
            end else begin
                d = gpr[it.v1[RegIdxW-1:0]];
                case (it.op)
                    OP_ADD: res = d + b;
                    OP_ADC: begin
                        wide = {1'b0, d} + {1'b0, b} + {8'd0, carry};
                        res = wide[7:0];
                        s = $signed(d) + $signed(b) + int'(carry);
                        if (wide[8]) carry = 1'b1;
                        if (s > 127 || s < -128) ovf = 1'b1;
                    end
                    OP_SUB: res = d - b;
                    OP_SBC: begin
                        // result and flags use the carry from before this item
                        s = $signed(d) - $signed(b) - int'(carry);
                        res = d - b - {7'd0, carry};
                        if (int'(d) < int'(b) + int'(carry)) carry = 1'b1;
                        if (s > 127 || s < -128) ovf = 1'b1;
                    end
                    OP_MUL: res = d * b;
                    OP_DIV: res = (b == 0) ? 8'hFF : d / b;
                    OP_SHL: res = (b >= 8) ? 8'd0 : d << b;
                    default: res = (b >= 8) ? 8'd0 : d >> b;
                endcase
                gpr[it.v1[RegIdxW-1:0]] = res;
                nzero = (res != 0);
            end
        end else if (it.op == OP_CLC) begin
            carry = 1'b0;
        end else if (it.op == OP_CLV) begin
            ovf = 1'b0;
        end else if (it.op == OP_NEG) begin
            if (!it.r2 || it.v2 >= RegCount) o.status = ST_BAD_OPD;
            else gpr[it.v2[RegIdxW-1:0]] = -gpr[it.v2[RegIdxW-1:0]];
        end else if (it.op == OP_STR) begin
            if (!fetch_operand(it.v1, it.r1, it.l1, a) ||
                !fetch_operand(it.v2, it.r2, it.l2, b))
                o.status = ST_BAD_OPD;
            else dmem[a[MemAddrW-1:0]] = b;
        end else if (it.op == OP_LD) begin
            if (!dest_valid(it) || !fetch_operand(it.v2, it.r2, it.l2, b))
                o.status = ST_BAD_OPD;
            else gpr[it.v1[RegIdxW-1:0]] = dmem[b[MemAddrW-1:0]];
        end else if (it.op == OP_CMP) begin
            if (!fetch_operand(it.v1, it.r1, it.l1, a) ||
                !fetch_operand(it.v2, it.r2, it.l2, b))
                o.status = ST_BAD_OPD;
            else cmp_flags = {a < b, a > b, a == b, a != b};
        end else if (it.op >= OP_JMP && it.op <= OP_JZ) begin
            if (!it.l1 || it.v1 >= LabelCount) begin
                o.status = ST_BAD_OPD;
            end else begin
                case (it.op)
                    OP_JMP:  take = 1;
                    OP_JNE:  take = cmp_flags[0];
                    OP_JE:   take = cmp_flags[1];
                    OP_JGT:  take = cmp_flags[2];
                    OP_JLT:  take = cmp_flags[3];
                    OP_JNZ:  take = nzero;
                    default: take = !nzero;
                endcase
                if (take) o.next = labels[it.v1[LabIdxW-1:0]];
            end
        end else if (it.op >= OP_PRC && it.op <= OP_PRU) begin
            if (!fetch_operand(it.v1, it.r1, it.l1, a)) begin
                o.status = ST_BAD_OPD;
            end else begin
                o.pvalid = 1'b1;
                o.pkind = 2'(it.op - OP_PRC);
                o.pval = a;
            end
        end else if (it.op == OP_HLT) begin
            o.status = ST_HALTED;
        end else if (it.op == OP_LBL) begin
            if (!it.l1 || it.v1 >= LabelCount) o.status = ST_BAD_OPD;
            else labels[it.v1[LabIdxW-1:0]] = it.v2;
        end else if (it.op != OP_NOP) begin
            o.status = ST_BAD_INS;
        end
        if (o.status != ST_OK) o.next = ip;
        ip = o.next;
        return o;
    endfunction

    // Mostly well-formed instructions: small register indices, few label bits
    function automatic t_instr random_instr();
        t_instr it;
        it.op = (($urandom_range(0, 99)) < 3) ? 5'($urandom_range(28, 31))
                                             : 5'($urandom_range(0, 27));
        it = '{op: it.op, default: '0};
        it.v1 = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        it.r1 = 1'($urandom_range(0, 9) < 7);
        it.l1 = 1'($urandom_range(0, 9) < 1);
        it.v2 = 8'($urandom);
        it.r2 = 1'($urandom_range(0, 1));
        it.l2 = 1'($urandom_range(0, 19) < 1);
        if (it.r2 && $urandom_range(0, 9) < 8) it.v2 = 8'($urandom_range(0, 7));
        if (it.op >= OP_JMP && it.op <= OP_JZ || it.op == OP_LBL) begin
            it.l1 = 1'($urandom_range(0, 9) < 9);
            it.r1 = 1'($urandom_range(0, 9) < 1);
            it.v1 = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        end
        if (it.op == OP_STR) it.r1 = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_instr mk(input logic [4:0] op, input logic [7:0] v1,
                                  input logic r1, input logic l1, input logic [7:0] v2,
                                  input logic r2, input logic l2);
        return '{l2: l2, r2: r2, v2: v2, l1: l1, r1: r1, v1: v1, op: op};
    endfunction

    // Driver: presents queued items, changing at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_q) begin
            if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tdata  <= {7'd0, pending_instrs.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

    // Monitor: predicts on accept, checks on result
    always @(posedge i_clk) begin
        t_outcome got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_outcomes.push_back(execute_instr(t_instr'(s_axis_tdata[24:0])));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_outcome'(m_axis_tdata[20:0]);
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches = mismatches + 1;
            end else begin
                want = expected_outcomes.pop_front();
                checked = checked + 1;
                if (got.pvalid) prints_seen = prints_seen + 1;
                if (got !== want) begin
                    $display("%0t: expected st=%0d nx=%h pv=%b pk=%0d val=%h,",
                             $time, want.status, want.next, want.pvalid, want.pkind,
                             want.pval);
                    $display("    got st=%0d nx=%h pv=%b pk=%0d val=%h",
                             got.status, got.next, got.pvalid, got.pkind, got.pval);
                    mismatches = mismatches + 1;
                end
            end
        end
        if (cycle_count > 400000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic drain();
        while (pending_instrs.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        cycle_count = 0;
        mismatches = 0;
        checked = 0;
        prints_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        foreach (labels[i]) labels[i] = '0;
        {carry, ovf, nzero, cmp_flags, ip} = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, carry/overflow, divide by zero, big shifts, bad operands
        pending_instrs.push_back(mk(OP_MOV, 0, 1, 0, 8'hFF, 0, 0));
        pending_instrs.push_back(mk(OP_ADC, 0, 1, 0, 8'h01, 0, 0));
        pending_instrs.push_back(mk(OP_ADC, 0, 1, 0, 8'h7F, 0, 0));
        pending_instrs.push_back(mk(OP_SBC, 0, 1, 0, 8'hFF, 0, 0));
        pending_instrs.push_back(mk(OP_CLC, 0, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_CLV, 0, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_MOV, 7, 1, 0, 8'h80, 0, 0));
        pending_instrs.push_back(mk(OP_SBC, 7, 1, 0, 8'h01, 0, 0));
        pending_instrs.push_back(mk(OP_DIV, 7, 1, 0, 8'h00, 0, 0));
        pending_instrs.push_back(mk(OP_SHL, 7, 1, 0, 8'd8, 0, 0));
        pending_instrs.push_back(mk(OP_SHR, 0, 1, 0, 8'd255, 0, 0));
        pending_instrs.push_back(mk(OP_MUL, 8'hFF, 1, 0, 1, 0, 0));
        pending_instrs.push_back(mk(OP_NEG, 0, 0, 0, 7, 1, 0));
        pending_instrs.push_back(mk(OP_STR, 8'hFF, 0, 0, 7, 1, 0));
        pending_instrs.push_back(mk(OP_LD, 1, 1, 0, 8'hFF, 0, 0));
        pending_instrs.push_back(mk(OP_LBL, 15, 0, 1, 8'hA5, 0, 0));
        pending_instrs.push_back(mk(OP_LBL, 16, 0, 1, 8'h11, 0, 0));
        pending_instrs.push_back(mk(OP_CMP, 1, 1, 0, 8'h00, 0, 0));
        pending_instrs.push_back(mk(OP_JGT, 15, 0, 1, 0, 0, 0));
        pending_instrs.push_back(mk(OP_JMP, 3, 1, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_PRS, 7, 1, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_PRU, 8'hFF, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_PRC, 0, 0, 1, 0, 0, 0));
        pending_instrs.push_back(mk(OP_HLT, 0, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(5'd31, 8'hFF, 1, 1, 8'hFF, 1, 1));
        drain();

        // Random phases with varied idling on both sides
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 71) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 23 : 71) : 0;
            for (int n = 0; n < 250; n++) pending_instrs.push_back(random_instr());
            if (ph == 0) begin
                drain();
                repeat (12) @(posedge i_clk);
            end
            drain();
        end
        repeat (30) @(posedge i_clk);

        $display("Checked %0d results, %0d of them prints, over four idling phases.",
                 checked, prints_seen);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
